>>> rtl/aes_pkg.sv
`timescale 1ns / 1ps
package aes_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int CFG_INDEX_WIDTH = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_KEY_HIGH     = 2'd0,
        REG_KEY_LOW      = 2'd1,
        REG_CTR_HIGH     = 2'd2,
        REG_CTR_LOW      = 2'd3
    } cfg_reg_t;

    // per-stage sideband: data halves travel with the block
    typedef struct packed {
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic        last_block;
    } side_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] tbl [256];
        tbl = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return tbl[x];
    endfunction

    function automatic logic [7:0] rcon(input int r);
        logic [7:0] v;
        v = 8'h01;
        for (int i = 1; i < NUM_ROUNDS; i++)
        begin
            if (i < r)
            begin
                v = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
            end
        end
        return v;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte n of a state sits in bits 127-8n .. 120-8n (big-endian)
    function automatic logic [7:0] byte_at(input logic [127:0] s, input int n);
        return s[127-8*n -: 8];
    endfunction

    // SubBytes, ShiftRows and optionally MixColumns
    function automatic logic [127:0] round_core(input logic [127:0] s, input logic mix);
        logic [7:0] t [16];
        logic [127:0] o;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                t[i+4*c] = sbox(byte_at(s, i + 4*((c+i) & 3)));
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (mix)
            begin
                o[127-32*c -: 32] = {a0 ^ al ^ xt(a0 ^ a1), a1 ^ al ^ xt(a1 ^ a2),
                                     a2 ^ al ^ xt(a2 ^ a3), a3 ^ al ^ xt(a3 ^ a0)};
            end
            else
            begin
                o[127-32*c -: 32] = {a0, a1, a2, a3};
            end
        end
        return o;
    endfunction

    // next round key from the previous one
    function automatic logic [127:0] next_key(input logic [127:0] k, input int r);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

>>> rtl/aes_if.sv
`timescale 1ns / 1ps
interface aes_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] block_index;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic        last_block;
    modport source (output valid, block_index, data_high, data_low, last_block, input ready);
    modport sink (input valid, block_index, data_high, data_low, last_block, output ready);
endinterface

interface aes_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic        last_out;
    modport source (output valid, result_high, result_low, last_out, input ready);
    modport sink (input valid, result_high, result_low, last_out, output ready);
endinterface

interface aes_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/aes_key_sched.sv
`timescale 1ns / 1ps
module aes_key_sched
    import aes_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic [127:0]         key,
    output logic [127:0]         round_keys [NUM_ROUNDS+1]
);
    // round keys computed one per cycle after a key write, held until the next
    logic [127:0] rk_reg [NUM_ROUNDS+1];
    logic [3:0]   step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 4'd1;
            for (int i = 0; i <= NUM_ROUNDS; i++)
            begin
                rk_reg[i] <= (i == 0) ? 128'd0 : 128'd0;
            end
            // zero-key schedule rebuilt by the stepping below
        end
        else if (load)
        begin
            rk_reg[0] <= key;
            step_reg  <= 4'd1;
        end
        else if (step_reg <= 4'(NUM_ROUNDS))
        begin
            rk_reg[step_reg] <= next_key(rk_reg[step_reg-4'd1], int'(step_reg));
            step_reg <= step_reg + 4'd1;
        end
    end

    assign round_keys = rk_reg;
endmodule

>>> rtl/aes_round_pipe.sv
`timescale 1ns / 1ps
module aes_round_pipe
    import aes_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  logic         in_valid,
    input  logic [127:0] in_state,
    input  side_t        in_side,
    input  logic [127:0] round_keys [NUM_ROUNDS+1],
    output logic         out_valid,
    output logic [127:0] out_state,
    output side_t        out_side
);
    // one round per stage; stage 0 holds the whitened counter
    logic [127:0] st_reg [NUM_ROUNDS+1];
    side_t        sd_reg [NUM_ROUNDS+1];
    logic         v_reg  [NUM_ROUNDS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NUM_ROUNDS; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= NUM_ROUNDS; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st_reg[0] <= in_state ^ round_keys[0];
            sd_reg[0] <= in_side;
            for (int i = 1; i <= NUM_ROUNDS; i++)
            begin
                st_reg[i] <= round_core(st_reg[i-1], i != NUM_ROUNDS) ^ round_keys[i];
                sd_reg[i] <= sd_reg[i-1];
            end
        end
    end

    assign out_valid = v_reg[NUM_ROUNDS];
    assign out_state = st_reg[NUM_ROUNDS];
    assign out_side  = sd_reg[NUM_ROUNDS];
endmodule

>>> rtl/aes128_ctr_block_crypt.sv
`timescale 1ns / 1ps
// AES-128 counter-mode engine. One 16-byte block enters per cycle while the
// pipeline advances; its result passes through one counter-add stage, eleven
// round stages and one output register, so throughput is one block per clock
// while the output is taken. The whole pipeline halts when the output register
// is full and not taken. After a key write the round-key schedule must settle
// before use; configure only while idle.
module aes128_ctr_block_crypt
    import aes_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    aes_cfg_if.sink   cfg,
    aes_in_if.sink    in_ch,
    aes_out_if.source out_ch
);
    logic [63:0] key_high_reg, key_low_reg, ctr_high_reg, ctr_low_reg;
    logic        key_load;
    logic [127:0] round_keys [NUM_ROUNDS+1];

    assign cfg.ready = 1'b1;
    assign key_load  = cfg.valid && (cfg.index == REG_KEY_HIGH || cfg.index == REG_KEY_LOW);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            ctr_high_reg <= '0;
            ctr_low_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_KEY_HIGH: key_high_reg <= cfg.data;
                REG_KEY_LOW:  key_low_reg  <= cfg.data;
                REG_CTR_HIGH: ctr_high_reg <= cfg.data;
                REG_CTR_LOW:  ctr_low_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    logic [127:0] key_next;
    assign key_next = (cfg.index == REG_KEY_HIGH) ? {cfg.data, key_low_reg}
                                                  : {key_high_reg, cfg.data};

    aes_key_sched u_sched (
        .clk(clk), .rst_n(rst_n), .load(key_load), .key(key_next),
        .round_keys(round_keys)
    );

    // pipeline advances unless the output register holds an untaken result
    logic advance;
    logic out_valid_reg;
    assign advance     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = advance;

    // counter add stage
    logic         c_valid_reg;
    logic [127:0] c_state_reg;
    side_t        c_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            c_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_state_reg <= {ctr_high_reg, ctr_low_reg} + {96'd0, in_ch.block_index};
            c_side_reg  <= '{data_high: in_ch.data_high, data_low: in_ch.data_low,
                             last_block: in_ch.last_block};
        end
    end

    logic         p_valid;
    logic [127:0] p_state;
    side_t        p_side;

    aes_round_pipe u_rounds (
        .clk(clk), .rst_n(rst_n), .advance(advance),
        .in_valid(c_valid_reg), .in_state(c_state_reg), .in_side(c_side_reg),
        .round_keys(round_keys),
        .out_valid(p_valid), .out_state(p_state), .out_side(p_side)
    );

    // output register
    logic [127:0] res_reg;
    logic         last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= p_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg  <= {p_side.data_high, p_side.data_low} ^ p_state;
            last_reg <= p_side.last_block;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.result_high = res_reg[127:64];
    assign out_ch.result_low  = res_reg[63:0];
    assign out_ch.last_out    = last_reg;

    // a stalled result must hold
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res_reg))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ch.ready)
        else $error("input blocked with empty output");
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(c_state_reg))
        else $error("counter stage moved while halted");
endmodule
